FILE: hw/rtl/htfd_pkg.sv
// shared types, constants and the crc-8 byte step for the frame decoder
// no dependencies

package htfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  // product widths of the constant scalings
  localparam int unsigned ProdCW = 31;
  localparam int unsigned ProdFW = 31;
  localparam int unsigned ProdHW = 30;

  localparam logic [ProdCW-1:0] KCentiC = ProdCW'(17500);
  localparam logic [ProdFW-1:0] KCentiF = ProdFW'(31500);
  localparam logic [ProdHW-1:0] KCentiH = ProdHW'(10000);

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  // position of a byte inside the six-byte frame
  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } byte_pos_e;

  // completed frame handed from the assembler to the result stage
  typedef struct packed {
    logic              valid;
    logic [WordW-1:0]  raw_t;
    logic [WordW-1:0]  raw_h;
    logic              crc_good;
    logic [ProdCW-1:0] prod_c;
    logic [ProdFW-1:0] prod_f;
    logic [ProdHW-1:0] prod_h;
  } frame_t;

  // msb-first crc-8 update over one byte
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/htfd_frame.sv
// input register and frame assembler: byte position, raw words, crc and products
// depends on htfd_pkg

module htfd_frame (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] rx_byte
  input  logic                     s_axis_tuser,   // [0] frame_start
  input  logic                     out_free_i,
  output htfd_pkg::frame_t         frame_o
);
  import htfd_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;

  byte_pos_e        pos_q, pos_d;
  byte_pos_e        pos_eff;
  logic             is_final;
  logic             fire;

  logic [WordW-1:0]  raw_t_q;
  logic [WordW-1:0]  raw_h_q;
  logic [ByteW-1:0]  crc_q;
  logic              crc_t_ok_q;
  logic [ProdCW-1:0] prod_c_q;
  logic [ProdFW-1:0] prod_f_q;
  logic [ProdHW-1:0] prod_h_q;

  // a frame start or an unreachable position falls back to the first byte
  always_comb begin
    if (in_start_q || (pos_q > POS_H_CRC)) begin
      pos_eff = POS_T_MSB;
    end else begin
      pos_eff = pos_q;
    end
  end

  assign is_final      = (pos_eff == POS_H_CRC);
  assign fire          = in_valid_q && (!is_final || out_free_i);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    if (is_final) begin
      pos_d = POS_T_MSB;
    end else begin
      pos_d = byte_pos_e'(pos_eff + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= POS_T_MSB;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      case (pos_eff)
        POS_T_MSB: begin
          raw_t_q[15:8] <= in_byte_q;
          crc_q         <= crc8_byte(CrcInit, in_byte_q);
        end
        POS_T_LSB: begin
          raw_t_q[7:0] <= in_byte_q;
          crc_q        <= crc8_byte(crc_q, in_byte_q);
          prod_c_q     <= ProdCW'({raw_t_q[15:8], in_byte_q}) * KCentiC;
          prod_f_q     <= ProdFW'({raw_t_q[15:8], in_byte_q}) * KCentiF;
        end
        POS_T_CRC: begin
          crc_t_ok_q <= (crc_q == in_byte_q);
        end
        POS_H_MSB: begin
          raw_h_q[15:8] <= in_byte_q;
          crc_q         <= crc8_byte(CrcInit, in_byte_q);
        end
        POS_H_LSB: begin
          raw_h_q[7:0] <= in_byte_q;
          crc_q        <= crc8_byte(crc_q, in_byte_q);
          prod_h_q     <= ProdHW'({raw_h_q[15:8], in_byte_q}) * KCentiH;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    frame_o.valid    = fire && is_final;
    frame_o.raw_t    = raw_t_q;
    frame_o.raw_h    = raw_h_q;
    frame_o.crc_good = crc_t_ok_q && (crc_q == in_byte_q);
    frame_o.prod_c   = prod_c_q;
    frame_o.prod_f   = prod_f_q;
    frame_o.prod_h   = prod_h_q;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_H_CRC)
    else $error("byte position out of range");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !is_final |=> pos_q == byte_pos_e'($past(pos_eff) + 3'd1))
    else $error("byte position did not advance");

  a_final_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_final |=> pos_q == POS_T_MSB)
    else $error("byte position did not wrap after last byte");

  a_stall_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |-> is_final && !out_free_i)
    else $error("input stage stalled without a blocked result");

endmodule

FILE: hw/rtl/htfd_result.sv
// result stage: divide by 65535, apply offsets, crc gating and output register
// depends on htfd_pkg

module htfd_result (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  htfd_pkg::frame_t frame_i,
  output logic             out_free_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [15:0] raw_temperature, [31:16] raw_humidity, [46:32] temp_centi_c,
  // [62:47] temp_centi_f, [76:63] humidity_centi, [79:77] zero
  output logic [79:0]      m_axis_tdata,
  output logic             m_axis_tuser    // [0] crc_good
);
  import htfd_pkg::*;

  // floor(x / 65535) for x below 2^31: x>>16 is at most one short
  function automatic logic [15:0] div_65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return {1'b0, q0} + {15'd0, (r >= 17'd65535)};
  endfunction

  logic [15:0] q_c, q_f, q_h;
  logic [15:0] tc_full;
  logic [16:0] tf_full;

  logic              out_valid_q;
  logic [WordW-1:0]  raw_t_q, raw_h_q;
  logic              crc_good_q;
  logic [14:0]       tc_q, tc_d;
  logic [15:0]       tf_q, tf_d;
  logic [13:0]       hc_q, hc_d;

  assign q_c = div_65535(frame_i.prod_c);
  assign q_f = div_65535(frame_i.prod_f);
  assign q_h = div_65535({1'b0, frame_i.prod_h});

  assign tc_full = q_c - 16'd4500;
  assign tf_full = {1'b0, q_f} - 17'd4900;

  always_comb begin
    if (frame_i.crc_good) begin
      tc_d = tc_full[14:0];
      tf_d = tf_full[15:0];
      hc_d = q_h[13:0];
    end else begin
      tc_d = '0;
      tf_d = '0;
      hc_d = '0;
    end
  end

  assign out_free_o = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_i.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      raw_t_q    <= frame_i.raw_t;
      raw_h_q    <= frame_i.raw_h;
      crc_good_q <= frame_i.crc_good;
      tc_q       <= tc_d;
      tf_q       <= tf_d;
      hc_q       <= hc_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = crc_good_q;
  assign m_axis_tdata  = {3'b000, hc_q, tf_q, tc_q, raw_h_q, raw_t_q};

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid |-> !out_valid_q || m_axis_tready)
    else $error("result register overwritten before transaction");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid |=> out_valid_q)
    else $error("loaded result not presented");

  a_bad_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !crc_good_q |-> tc_q == '0 && tf_q == '0 && hc_q == '0)
    else $error("converted values not zero on crc failure");

  a_humidity_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> hc_q <= 14'd10000)
    else $error("humidity out of range");

endmodule

FILE: hw/rtl/humidity_temp_frame_decoder.sv
// Decoder for a humidity/temperature sensor measurement frame.
// Input stream: one frame byte per transaction in sensor order (temperature
// msb, lsb, crc, humidity msb, lsb, crc); tuser high marks the first byte of
// a frame and drops any partial one. Without it bytes are numbered 0..5 in
// turn and wrap after the sixth.
// Output stream: one transaction per completed frame with the raw words, the
// crc flag in tuser and temperature in 0.01 degC / 0.01 degF and humidity in
// 0.01 %RH; converted values are zero when either crc-8 (0x31, init 0xff)
// fails.
// Throughput: one byte per cycle, except that the sixth byte waits in the
// input register until the result register is free. Accepting the sixth
// byte loads the input register, which then loads the result register.
// Products are formed when the second byte of each word arrives, so the
// last cycle only holds the divide-by-65535 correction, the offsets and the crc check and gating.
// When the receiver stalls the result holds; further bytes are still taken
// until the next sixth byte reaches the input register, which then waits.
// Reset clears the byte position and both stream valids; stored bytes keep
// their contents.
// depends on htfd_pkg, htfd_frame, htfd_result

module humidity_temp_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] raw_temperature, [31:16] raw_humidity, [46:32] temp_centi_c,
  // [62:47] temp_centi_f, [76:63] humidity_centi, [79:77] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] crc_good
);
  import htfd_pkg::*;

  frame_t frame;
  logic   out_free;

  htfd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .out_free_i    (out_free),
    .frame_o       (frame)
  );

  htfd_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: dv/humidity_temp_frame_decoder_test.sv
// self-checking testbench for the humidity/temperature frame decoder
// predicts each decoded frame from the byte stream and checks every output transaction
// depends on htfd_pkg and humidity_temp_frame_decoder

`timescale 1ns / 100ps

module humidity_temp_frame_decoder_test;
  import htfd_pkg::*;

  localparam int unsigned ByteTarget = 650;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] rx;
    logic       start;
    logic       drain;
  } rx_item_t;

  typedef struct packed {
    logic [15:0]        raw_t;
    logic [15:0]        raw_h;
    logic               crc_ok;
    logic signed [14:0] centi_c;
    logic signed [15:0] centi_f;
    logic [13:0]        centi_h;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0; // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] raw_temperature, [31:16] raw_humidity, [46:32] temp_centi_c,
  // [62:47] temp_centi_f, [76:63] humidity_centi, [79:77] zero
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;        // [0] crc_good

  rx_item_t  byte_q[$];
  reading_t  reading_q[$];

  // predictor state
  byte_pos_e   next_pos = POS_T_MSB;
  logic [7:0]  held_bytes [5];

  rx_item_t    cur_item = '0;
  bit          presenting = 1'b0;
  bit          in_taken = 1'b0;
  bit          drain_next = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned phase_left = 0;
  int unsigned sink_mode = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned frames_checked = 0;
  int unsigned crc_fail_checked = 0;
  int unsigned restarts_queued = 0;

  humidity_temp_frame_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // crc-8, poly 0x31, init 0xff, one bit at a time over the 16-bit word
  function automatic logic [7:0] word_checksum(logic [15:0] word);
    logic [7:0] c;
    logic       fb;
    c = 8'hFF;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ word[i];
      c = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
    end
    return c;
  endfunction

  function automatic void absorb_byte(logic [7:0] rx, logic start);
    byte_pos_e pos;
    reading_t  r;
    longint    tc;
    longint    tf;
    longint    hc;
    pos = start ? POS_T_MSB : next_pos;
    if (pos != POS_H_CRC) begin
      held_bytes[int'(pos)] = rx;
      next_pos = byte_pos_e'(pos + 3'd1);
      return;
    end
    next_pos = POS_T_MSB;
    r = '0;
    r.raw_t = {held_bytes[int'(POS_T_MSB)], held_bytes[int'(POS_T_LSB)]};
    r.raw_h = {held_bytes[int'(POS_H_MSB)], held_bytes[int'(POS_H_LSB)]};
    r.crc_ok = (word_checksum(r.raw_t) == held_bytes[int'(POS_T_CRC)]) &&
               (word_checksum(r.raw_h) == rx);
    if (r.crc_ok) begin
      tc = (longint'(17500) * longint'(r.raw_t)) / 65535 - 4500;
      tf = (longint'(31500) * longint'(r.raw_t)) / 65535 - 4900;
      hc = (longint'(10000) * longint'(r.raw_h)) / 65535;
      r.centi_c = tc[14:0];
      r.centi_f = tf[15:0];
      r.centi_h = hc[13:0];
    end
    reading_q.push_back(r);
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      error_count++;
    end
  endtask

  // monitor: checks output transactions, feeds accepted input transactions to the predictor
  always @(posedge clk_i) begin
    reading_t want;
    reading_t seen;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.raw_t   = m_axis_tdata[15:0];
        seen.raw_h   = m_axis_tdata[31:16];
        seen.centi_c = m_axis_tdata[46:32];
        seen.centi_f = m_axis_tdata[62:47];
        seen.centi_h = m_axis_tdata[76:63];
        seen.crc_ok  = m_axis_tuser;
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h / %b", $time,
                   m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = reading_q.pop_front();
          frames_checked++;
          if (!want.crc_ok) crc_fail_checked++;
          check_field("raw_temperature", want.raw_t, seen.raw_t);
          check_field("raw_humidity", want.raw_h, seen.raw_h);
          check_field("crc_good", 16'(want.crc_ok), 16'(seen.crc_ok));
          check_field("temp_centi_c", 16'(want.centi_c), 16'(seen.centi_c));
          check_field("temp_centi_f", want.centi_f, seen.centi_f);
          check_field("humidity_centi", 16'(want.centi_h), 16'(seen.centi_h));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(s_axis_tdata, s_axis_tuser);
        in_taken = 1'b1;
      end
    end
  end

  // driver: bursts of bytes with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (presenting && in_taken) presenting = 1'b0;
      in_taken = 1'b0;
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].drain && reading_q.size() != 0)) begin
          cur_item = byte_q.pop_front();
          presenting = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_axis_tvalid <= presenting;
      s_axis_tdata  <= cur_item.rx;
      s_axis_tuser  <= cur_item.start;
    end
  end

  // receiver: phases of full rate, light stall, heavy stall and full stall
  always @(negedge clk_i) begin
    logic rdy;
    if (rst_ni) begin
      if (phase_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 64);
      end else begin
        phase_left--;
      end
      case (sink_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = 1'b0;
      endcase
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] rx, logic start);
    rx_item_t it;
    it.rx = rx;
    it.start = start;
    it.drain = drain_next;
    drain_next = 1'b0;
    byte_q.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_frame(logic [15:0] t, logic [15:0] h, logic start,
                            bit bad_t, bit bad_h);
    logic [7:0] ct;
    logic [7:0] ch;
    ct = word_checksum(t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
    ch = word_checksum(h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
    push_byte(t[15:8], start);
    push_byte(t[7:0], 1'b0);
    push_byte(ct, 1'b0);
    push_byte(h[15:8], 1'b0);
    push_byte(h[7:0], 1'b0);
    push_byte(ch, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    bit          aligned;
    bit          drain_done;
    int unsigned kind;
    int unsigned n;
    logic        st;

    // directed: extremes, free-running wrap, restart, crc failure on each word
    push_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h55, 1'b0);
    restarts_queued++;
    push_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
    push_frame(16'hBEEF, 16'h1234, 1'b1, 1'b1, 1'b0);

    aligned = 1'b1;
    drain_done = 1'b0;
    while (bytes_queued < ByteTarget) begin
      if (!drain_done && bytes_queued > ByteTarget / 2) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      st = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
      if (!aligned) restarts_queued++;
      if (kind < 70) begin
        push_frame(pick_word(), pick_word(), st, 1'b0, 1'b0);
        aligned = 1'b1;
      end else if (kind < 80) begin
        n = $urandom_range(0, 2);
        push_frame(pick_word(), pick_word(), st, n != 1, n != 0);
        aligned = 1'b1;
      end else if (kind < 90) begin
        n = $urandom_range(1, 5);
        push_byte(8'($urandom), st);
        for (int i = 1; i < n; i++) push_byte(8'($urandom), 1'b0);
        aligned = 1'b0;
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
        aligned = 1'b0;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || presenting) @(posedge clk_i);
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d bytes sent, %0d frames checked (%0d with crc failure), %0d restarts",
             bytes_queued, frames_checked, crc_fail_checked, restarts_queued);
    $display("%0d mismatches in %0d cycles", error_count, cycle_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_frame.sv
hw/rtl/htfd_result.sv
hw/rtl/humidity_temp_frame_decoder.sv
dv/humidity_temp_frame_decoder_test.sv
